### src/bpec_pkg.sv
`default_nettype none
package bpec_pkg;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_BITS_PER_PIXEL   = 3'd0;
  localparam cfg_index_t CFG_USE_565          = 3'd1;
  localparam cfg_index_t CFG_COLOR_ENABLE     = 3'd2;
  localparam cfg_index_t CFG_MULTICOLOR_PANEL = 3'd3;
  localparam cfg_index_t CFG_SHOWN_WIDTH      = 3'd4;
  localparam cfg_index_t CFG_ROW_BYTES        = 3'd5;

  localparam logic [4:0] DEPTH_1  = 5'd1;
  localparam logic [4:0] DEPTH_4  = 5'd4;
  localparam logic [4:0] DEPTH_8  = 5'd8;
  localparam logic [4:0] DEPTH_16 = 5'd16;
  localparam logic [4:0] DEPTH_24 = 5'd24;

  localparam logic [15:0] WHITE_CODE   = 16'hFFFF;
  localparam logic [15:0] BLACK_CODE   = 16'h0000;
  localparam logic [15:0] COLORED_CODE = 16'hF800;

  localparam logic [7:0] WHITE_LEVEL = 8'h80;
  localparam logic [7:0] COLOR_LEVEL = 8'hF0;
  localparam logic [9:0] WHITE_SUM   = 10'd384;

  typedef struct packed {
    logic        white;
    logic        colored;
    logic [15:0] rgb;
  } pal_entry_t;

  function automatic logic is_whitish(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic color_on);
    logic [9:0] sum;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    if (color_on) begin
      return (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
    end
    return sum > WHITE_SUM;
  endfunction

  function automatic logic is_colored(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] final_color(input pal_entry_t e, input logic color_on,
                                              input logic multicolor);
    if (color_on && multicolor) begin
      return e.rgb;
    end
    if (e.white) begin
      return WHITE_CODE;
    end
    if (e.colored && color_on) begin
      return COLORED_CODE;
    end
    return BLACK_CODE;
  endfunction

endpackage
`default_nettype wire

### src/bmp_pixel_to_epaper_color_unit.sv
`default_nettype none
// Converts a bitmap byte stream into one display color per shown pixel.
// Palette entries (tuser = 0) are written to a PALETTE_ENTRIES deep table;
// image bytes (tuser = 1) are decoded at the configured depth. A byte is
// decoded one pixel at a time: up to eight pixels at depth 1 and two at
// depth 4 (fewer once the shown width of the row is reached), one at depth
// 8, 16 or 24. The single palette read port serves one pixel per cycle
// while the decoder is not stalled. An accepted byte passes the decoder, the
// palette read stage and the result register in that order; results leave at
// one per cycle while m_axis_tready is high, and a full result register stops
// the decoder only once the palette read stage behind it is full as well.
module bmp_pixel_to_epaper_color_unit #(
  parameter int MAX_ROW_PIXELS  = 1024,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // palette_index[7:0], red[15:8], green[23:16], blue[31:24], data_byte[39:32]
  input  wire logic [39:0]           s_axis_tdata,
  // kind[0]
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // pixel_color[15:0], column[25:16], row_end[26], zero[31:27]
  output logic [31:0]                m_axis_tdata,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_we,
  input  wire bpec_pkg::cfg_index_t  cfg_index,
  input  wire logic [11:0]           cfg_data
);
  import bpec_pkg::*;

  localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int MAX_CLIP = (MAX_ROW_PIXELS > 2047) ? 2047 : MAX_ROW_PIXELS;
  localparam logic [10:0] MAX_W = 11'(MAX_CLIP);
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  logic [4:0]  bits_per_pixel;
  logic        use_565;
  logic        color_enable;
  logic        multicolor_panel;
  logic [10:0] shown_width;
  logic [11:0] row_bytes;

  logic [11:0] row_byte_count;
  logic [10:0] pixel_column;
  logic [15:0] held_bytes;
  logic [1:0]  byte_phase;

  logic        a_valid;
  logic [7:0]  a_byte;
  logic [2:0]  a_k;

  logic        b_valid;
  logic        b_direct;
  logic        b_pal_ok;
  logic [15:0] b_color;
  logic [9:0]  b_column;
  logic        b_row_end;
  logic        b_last;
  pal_entry_t  pal_q;

  logic        out_valid;
  logic [15:0] out_color;
  logic [9:0]  out_column;
  logic        out_row_end;
  logic        out_last;

  pal_entry_t  palette_mem [PALETTE_ENTRIES];

  logic        color_on;
  logic [10:0] eff_w;
  logic        accept;
  logic        pal_we;
  logic        b_ready;
  logic        a_advance;
  logic        a_final;
  logic        a_emit;
  logic        a_direct;
  logic        a_pal_ok;
  logic [7:0]  pn;
  logic [2:0]  k_last;
  logic [15:0] a_color;
  logic [10:0] pixel_column_next;
  logic [15:0] held_bytes_next;
  logic [1:0]  byte_phase_next;
  logic [11:0] row_byte_count_next;
  logic [12:0] count_inc;
  logic [7:0]  in_r, in_g, in_b, in_d;
  logic [7:0]  dr, dg, db;
  logic [15:0] drgb;
  pal_entry_t  pal_wdata;
  pal_entry_t  pal_rd;
  pal_entry_t  direct_e;

  assign in_r = s_axis_tdata[15:8];
  assign in_g = s_axis_tdata[23:16];
  assign in_b = s_axis_tdata[31:24];
  assign in_d = s_axis_tdata[39:32];

  assign color_on = color_enable && (bits_per_pixel != DEPTH_1);
  assign eff_w = (shown_width < MAX_W) ? shown_width : MAX_W;

  assign b_ready = !out_valid || m_axis_tready;
  assign a_advance = a_valid && (!b_valid || b_ready);
  assign s_axis_tready = !a_valid || (a_advance && a_final);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pal_we = accept && !s_axis_tuser && ({1'b0, s_axis_tdata[7:0]} < PAL_LIMIT);

  always_comb begin
    pal_wdata.rgb = pack565(in_r, in_g, in_b);
    pal_wdata.white = is_whitish(in_r, in_g, in_b, color_on);
    pal_wdata.colored = is_colored(in_r, in_g, in_b);
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_mem[s_axis_tdata[PAL_AW-1:0]] <= pal_wdata;
    end
    if (a_advance) begin
      pal_q <= palette_mem[pn[PAL_AW-1:0]];
    end
  end

  always_comb begin
    pn = a_byte;
    k_last = 3'd0;
    a_direct = 1'b0;
    unique case (bits_per_pixel)
      DEPTH_1: begin
        pn = {7'd0, a_byte[3'd7 - a_k]};
        k_last = 3'd7;
      end
      DEPTH_4: begin
        pn = a_k[0] ? {4'd0, a_byte[3:0]} : {4'd0, a_byte[7:4]};
        k_last = 3'd1;
      end
      DEPTH_8: begin
        pn = a_byte;
      end
      default: begin
        a_direct = 1'b1;
      end
    endcase
  end

  assign a_pal_ok = ({1'b0, pn} < PAL_LIMIT);

  always_comb begin
    dr = a_byte;
    dg = held_bytes[15:8];
    db = held_bytes[7:0];
    drgb = pack565(dr, dg, db);
    if (bits_per_pixel == DEPTH_16) begin
      db = {held_bytes[4:0], 3'd0};
      if (use_565) begin
        dg = {a_byte[2:0], held_bytes[7:5], 2'd0};
        dr = {a_byte[7:3], 3'd0};
        drgb = {a_byte, held_bytes[7:0]};
      end else begin
        dg = {a_byte[1:0], held_bytes[7:5], 3'd0};
        dr = {a_byte[6:2], 3'd0};
        drgb = pack565(dr, dg, db);
      end
    end
    direct_e.rgb = drgb;
    direct_e.white = is_whitish(dr, dg, db, color_on);
    direct_e.colored = is_colored(dr, dg, db);
    a_color = final_color(direct_e, color_on, multicolor_panel);
  end

  always_comb begin
    a_emit = 1'b0;
    a_final = 1'b1;
    pixel_column_next = pixel_column;
    held_bytes_next = held_bytes;
    byte_phase_next = byte_phase;
    if (!a_direct) begin
      a_emit = pixel_column < eff_w;
      a_final = (a_k == k_last) || !a_emit || (pixel_column + 11'd1 == eff_w);
    end else if (bits_per_pixel == DEPTH_16) begin
      if (byte_phase == 2'd0) begin
        held_bytes_next = {8'd0, a_byte};
        byte_phase_next = 2'd1;
      end else begin
        a_emit = pixel_column < eff_w;
        held_bytes_next = 16'd0;
        byte_phase_next = 2'd0;
      end
    end else if (bits_per_pixel == DEPTH_24) begin
      if (byte_phase == 2'd0) begin
        held_bytes_next = {8'd0, a_byte};
        byte_phase_next = 2'd1;
      end else if (byte_phase == 2'd1) begin
        held_bytes_next = {a_byte, held_bytes[7:0]};
        byte_phase_next = 2'd2;
      end else begin
        a_emit = pixel_column < eff_w;
        held_bytes_next = 16'd0;
        byte_phase_next = 2'd0;
      end
    end
    if (a_emit) begin
      pixel_column_next = pixel_column + 11'd1;
    end
    count_inc = {1'b0, row_byte_count} + 13'd1;
    row_byte_count_next = count_inc[11:0];
    if (a_final && (count_inc >= {1'b0, row_bytes})) begin
      row_byte_count_next = 12'd0;
      pixel_column_next = 11'd0;
      held_bytes_next = 16'd0;
      byte_phase_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= DEPTH_24;
      use_565 <= 1'b0;
      color_enable <= 1'b0;
      multicolor_panel <= 1'b0;
      shown_width <= 11'd800;
      row_bytes <= 12'd2400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BITS_PER_PIXEL:   bits_per_pixel <= cfg_data[4:0];
        CFG_USE_565:          use_565 <= cfg_data[0];
        CFG_COLOR_ENABLE:     color_enable <= cfg_data[0];
        CFG_MULTICOLOR_PANEL: multicolor_panel <= cfg_data[0];
        CFG_SHOWN_WIDTH:      shown_width <= cfg_data[10:0];
        CFG_ROW_BYTES:        row_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_k <= 3'd0;
      row_byte_count <= 12'd0;
      pixel_column <= 11'd0;
      held_bytes <= 16'd0;
      byte_phase <= 2'd0;
    end else begin
      if (a_advance) begin
        if (a_final) begin
          a_valid <= 1'b0;
          a_k <= 3'd0;
          row_byte_count <= row_byte_count_next;
          held_bytes <= held_bytes_next;
          byte_phase <= byte_phase_next;
        end else begin
          a_k <= a_k + 3'd1;
        end
        pixel_column <= pixel_column_next;
      end
      if (accept && s_axis_tuser) begin
        a_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tuser) begin
      a_byte <= in_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_advance && a_emit) begin
        b_valid <= 1'b1;
      end else if (b_ready) begin
        b_valid <= 1'b0;
      end
      if (b_valid && b_ready) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      b_direct <= a_direct;
      b_pal_ok <= a_pal_ok;
      b_color <= a_color;
      b_column <= pixel_column[9:0];
      b_row_end <= (pixel_column + 11'd1 == eff_w);
      b_last <= a_final;
    end
  end

  always_comb begin
    pal_rd = b_pal_ok ? pal_q : '0;
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_ready) begin
      out_color <= b_direct ? b_color : final_color(pal_rd, color_on, multicolor_panel);
      out_column <= b_column;
      out_row_end <= b_row_end;
      out_last <= b_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, out_row_end, out_column, out_color};
  assign m_axis_tlast = out_last;

  assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_advance |=> a_valid && $stable(a_k) && $stable(a_byte))
    else $error("decoder step changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    b_valid && b_row_end |-> b_last)
    else $error("row end pixel not marked last of its byte");

  assert property (@(posedge clk) disable iff (rst)
    byte_phase != 2'd3)
    else $error("byte phase out of range");

endmodule
`default_nettype wire
